@@ hdl/wide_char_to_utf8_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the wide character to UTF-8 encoder
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WIDE_CHAR_TO_UTF8_ENCODER_MACROS_SVH
`define WIDE_CHAR_TO_UTF8_ENCODER_MACROS_SVH

`ifndef SYNTH
`define U8E_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("u8e check failed");
`define U8E_ASSERT_NEXT(label, trig, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("u8e check failed");
`else
`define U8E_ASSERT(label, prop)
`define U8E_ASSERT_NEXT(label, trig, prop)
`endif

`endif

@@ hdl/u8e_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_pkg
// Shared types, constants and the UTF-8 byte encoder function.
// ----------------------------------------------------------------------------
package u8e_pkg;

   localparam int JobBytes   = 7;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [31:0] SUR_HIGH_FIRST = 32'h0000_D800;
   localparam logic [31:0] SUR_HIGH_LAST  = 32'h0000_DBFF;
   localparam logic [31:0] SUR_LOW_FIRST  = 32'h0000_DC00;
   localparam logic [31:0] SUR_LOW_LAST   = 32'h0000_DFFF;
   localparam logic [31:0] SUPP_BASE      = 32'h0001_0000;
   localparam logic [31:0] CODE_MAX       = 32'h0010_FFFF;
   localparam logic [31:0] MAX_ONE        = 32'h0000_007F;
   localparam logic [31:0] MAX_TWO        = 32'h0000_07FF;
   localparam logic [31:0] MAX_THREE      = 32'h0000_FFFF;

   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;
   localparam logic [7:0] REPL_B0    = 8'hEF;
   localparam logic [7:0] REPL_B1    = 8'hBF;
   localparam logic [7:0] REPL_B2    = 8'hBD;

   // bytes of one code point, first byte at index 0
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } enc_type;

   // one queued job: up to seven bytes, first at index 0
   typedef struct packed {
      logic [JobBytes-1:0][7:0] bytes;
      logic [2:0]               count;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic enc_type encode_utf8(input logic [31:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp <= MAX_ONE) begin
         e.bytes[0] = cp[7:0];
         e.count    = 3'd1;
      end else if (cp <= MAX_TWO) begin
         e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
         e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
         e.count    = 3'd2;
      end else if (cp <= MAX_THREE) begin
         e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
         e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
         e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
         e.count    = 3'd3;
      end else if (cp <= CODE_MAX) begin
         e.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
         e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
         e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
         e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
         e.count    = 3'd4;
      end else begin
         e.bytes[0] = REPL_B0;
         e.bytes[1] = REPL_B1;
         e.bytes[2] = REPL_B2;
         e.count    = 3'd3;
      end
      return e;
   endfunction

endpackage

@@ hdl/u8e_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_front
// Accepts code units, pairs surrogates and encodes each request into a job
// of up to seven UTF-8 bytes for the queue.
// ----------------------------------------------------------------------------
module u8e_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_tvalid,
   output logic                      csr_tready,
   input  logic                      csr_combine,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_code_unit,
   input  logic                      req_last_unit,
   input  u8e_pkg::queue_status_type q_status,
   output logic                      push,
   output u8e_pkg::job_type          push_job
);
   import u8e_pkg::*;

   logic        combine_ff, combine_in;
   logic        pending_ff, pending_in;
   logic [9:0]  held_ff, held_in;
   logic        accept;
   logic        is_high, is_low;
   logic        pair, hold, prefix_en, cur_en;
   logic [20:0] pair_cp;
   enc_type     held_enc, cur_enc;
   logic [2:0]  cur_count;

   // config register is always writable
   assign csr_tready = 1'b1;
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // classify the unit
   assign is_high = (req_code_unit >= SUR_HIGH_FIRST) && (req_code_unit <= SUR_HIGH_LAST);
   assign is_low  = (req_code_unit >= SUR_LOW_FIRST) && (req_code_unit <= SUR_LOW_LAST);
   assign pair    = pending_ff && combine_ff && is_low;
   assign hold    = !pair && combine_ff && is_high && !req_last_unit;
   assign prefix_en = pending_ff && !pair;
   assign cur_en    = !hold;

   // supplementary code point from the held high and this low unit
   assign pair_cp  = {1'b0, held_ff, req_code_unit[9:0]} + SUPP_BASE[20:0];
   assign held_enc = encode_utf8(SUR_HIGH_FIRST | {22'd0, held_ff});
   assign cur_enc  = encode_utf8(pair ? {11'd0, pair_cp} : req_code_unit);
   assign cur_count = cur_en ? cur_enc.count : 3'd0;

   // pack the held unit bytes ahead of the current bytes
   always_comb begin
      push_job.bytes = '0;
      if (prefix_en) begin
         push_job.bytes[2:0] = held_enc.bytes[2:0];
         push_job.bytes[6:3] = cur_enc.bytes;
         push_job.count      = 3'd3 + cur_count;
      end else begin
         push_job.bytes[3:0] = cur_enc.bytes;
         push_job.count      = cur_count;
      end
   end

   assign push = accept && (push_job.count != 3'd0);

   // next surrogate state and config
   always_comb begin
      combine_in = csr_tvalid ? csr_combine : combine_ff;
      pending_in = pending_ff;
      held_in    = held_ff;
      if (accept) begin
         pending_in = hold;
         held_in    = hold ? req_code_unit[9:0] : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         combine_ff <= 1'b1;
         pending_ff <= 1'b0;
         held_ff    <= 10'd0;
      end else begin
         combine_ff <= combine_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
      end
   end

endmodule

@@ hdl/u8e_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module u8e_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  u8e_pkg::job_type          push_job,
   input  logic                      pop,
   output u8e_pkg::job_type          head_job,
   output u8e_pkg::queue_status_type status
);
   import u8e_pkg::*;

   job_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wptr_ff, wptr_in;
   logic [QueuePtrW-1:0]   rptr_ff, rptr_in;
   logic [QueuePtrW:0]     count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign head_job     = entries_ff[rptr_ff];

   // advance pointers and fill count
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // store the job
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/u8e_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8e_back
// Walks the head job one byte per cycle, while rsp_tready accepts, into the output register.
// ----------------------------------------------------------------------------
module u8e_back (
   input  logic                      clock,
   input  logic                      reset,
   input  u8e_pkg::job_type          head_job,
   input  u8e_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);
   import u8e_pkg::*;

   `include "wide_char_to_utf8_encoder_macros.svh"

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;

   // load a byte when the output register is empty or being drained
   assign load    = !q_status.empty && (!valid_ff || rsp_tready);
   assign last_in = (idx_ff == head_job.count - 3'd1);
   assign data_in = head_job.bytes[idx_ff];
   assign pop     = load && last_in;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last_in ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // hold payload unless a new byte loads
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   `U8E_ASSERT(a_idx_in_job, q_status.empty || (idx_ff < head_job.count))
   `U8E_ASSERT(a_job_nonzero, q_status.empty || (head_job.count != 3'd0))
   `U8E_ASSERT_NEXT(a_idx_restart, pop, idx_ff == 3'd0)
   `U8E_ASSERT_NEXT(a_pop_marks_last, pop, rsp_tvalid && rsp_tlast)

endmodule

@@ hdl/wide_char_to_utf8_encoder.sv @@
`timescale 1ns / 1ps
// With the queue empty, an accepted request is first written into the job queue,
// and its first byte is then registered into the output register on rsp_tdata.
// Throughput: one request per cycle while the job queue is not full; the output
// delivers one byte per cycle while rsp_tready is held, so a request producing N
// bytes (1..7) is walked out byte by byte, and the four-entry job queue absorbs bursts.
// Reset: synchronous, active high; clears the queue, pairing state and sets
// combine_surrogates to 1.
// ----------------------------------------------------------------------------
// wide_char_to_utf8_encoder
// Wide code units in, UTF-8 bytes out, with optional surrogate pairing.
// ----------------------------------------------------------------------------
module wide_char_to_utf8_encoder (
   input  logic        clock,
   input  logic        reset,
   // csr_tdata: [0] combine_surrogates, [7:1] zero
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata,
   // req_tdata: [31:0] code_unit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: [7:0] utf8_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);
   import u8e_pkg::*;

   logic             push, pop;
   job_type          push_job, head_job;
   queue_status_type q_status;

   u8e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_tvalid    (csr_tvalid),
      .csr_tready    (csr_tready),
      .csr_combine   (csr_tdata[0]),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_code_unit (req_tdata),
      .req_last_unit (req_tlast),
      .q_status      (q_status),
      .push          (push),
      .push_job      (push_job)
   );

   u8e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   u8e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
